/* hdl/rctc_pkg.sv */
// ----------------------------------------------------------------------------
// rctc_pkg
// shared constants and helpers of the row/column transition counter
// ----------------------------------------------------------------------------
package rctc_pkg;

  localparam int SIDE_DEF       = 32;
  localparam int PIXEL_BITS_DEF = 8;

  // fixed field widths
  localparam int PIXEL_W = 8;
  localparam int COUNT_W = 5;
  localparam int INDEX_W = 6;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  // saturating increment of a transition count
  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    return (c == COUNT_MAX) ? c : c + COUNT_W'(1);
  endfunction

endpackage

/* hdl/rctc_if.sv */
// ----------------------------------------------------------------------------
// rctc_if
// valid/ready channels of the row/column transition counter
// ----------------------------------------------------------------------------
interface rctc_pixel_if import rctc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface rctc_count_if import rctc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] feature_index;
  logic [COUNT_W-1:0] transition_count;
  logic               last;

  modport source (output valid, output feature_index, output transition_count,
                  output last, input ready);
  modport sink   (input valid, input feature_index, input transition_count,
                  input last, output ready);
endinterface

/* hdl/rctc_ram.sv */
// ----------------------------------------------------------------------------
// rctc_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module rctc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/row_column_transition_counter.sv */
// ----------------------------------------------------------------------------
// row_column_transition_counter
// counts horizontal transitions per row and vertical transitions per column
// of a square raster image, then emits all counts at the end of the image
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                                  | request
//  ---------+-----+------------------------------------------+---------------
//  pixels   | in  | pixel                                    | one pixel
//  counts   | out | feature_index, transition_count, last    | one count
//
//  pixels are taken at one per cycle while an image streams in
//  after the last pixel: a flush state, then one count per row and per column
//  (ram read, then output register), each read issued only once the previous
//  read has returned; pixels are refused meanwhile, and the last count
//  overlaps the next image
//  reset clears positions and control only; count rams need no clearing pass,
//  row counts are rewritten at each row end and column counts are written as
//  zero during the first row of every image
//  a stalled output holds its count; the drain issues no read until it can land
//
module row_column_transition_counter
  import rctc_pkg::*;
#(
  parameter int SIDE       = SIDE_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  rctc_pixel_if.sink   pixels,
  rctc_count_if.source counts
);

  localparam int IW       = $clog2(SIDE);
  localparam int KW       = $clog2(2 * SIDE);
  localparam int CMP_BITS = (PIXEL_BITS < PIXEL_W) ? PIXEL_BITS : PIXEL_W;

  typedef enum logic [1:0] {RUN, FLUSH, DRAIN} state_t;

  state_t state;

  // raster position of the next pixel
  logic [IW-1:0]       row;
  logic [IW-1:0]       col;
  logic [CMP_BITS-1:0] left_px;
  logic [COUNT_W-1:0]  row_acc;

  // column update stage, in the cycle after acceptance
  logic                s1_valid;
  logic [IW-1:0]       s1_col;
  logic                s1_first_row;
  logic [CMP_BITS-1:0] s1_px;

  // drain sequencer
  logic [KW-1:0]       k;
  logic                rd_pending;
  logic                rd_row;
  logic [INDEX_W-1:0]  rd_index;
  logic                rd_last;

  // output register
  logic                out_valid;
  logic [INDEX_W-1:0]  out_index;
  logic [COUNT_W-1:0]  out_count;
  logic                out_last;

  logic                accept;
  logic [CMP_BITS-1:0] px;
  logic                last_col;
  logic                last_row;
  logic [COUNT_W-1:0]  row_cnt_next;
  logic                issue;
  logic                k_in_rows;
  logic [KW-1:0]       k_col;
  logic [IW-1:0]       cc_raddr;
  logic [COUNT_W-1:0]  rc_rdata;
  logic [COUNT_W-1:0]  cc_rdata;
  logic [COUNT_W-1:0]  cc_wdata;
  logic [CMP_BITS-1:0] lb_rdata;

  assign pixels.ready = (state == RUN);
  assign accept       = pixels.valid && pixels.ready;
  assign px           = pixels.pixel[CMP_BITS-1:0];
  assign last_col     = (col == IW'(SIDE - 1));
  assign last_row     = (row == IW'(SIDE - 1));

  // horizontal transition against the left neighbour, not across row edges
  always_comb begin
    if (col == '0) begin
      row_cnt_next = '0;
    end else if (px != left_px) begin
      row_cnt_next = sat_inc(row_acc);
    end else begin
      row_cnt_next = row_acc;
    end
  end

  // vertical transition against the line buffer, first row writes zero
  always_comb begin
    if (s1_first_row) begin
      cc_wdata = '0;
    end else if (s1_px != lb_rdata) begin
      cc_wdata = sat_inc(cc_rdata);
    end else begin
      cc_wdata = cc_rdata;
    end
  end

  assign k_in_rows = (k < KW'(SIDE));
  assign k_col     = k - KW'(SIDE);
  assign cc_raddr  = (state == DRAIN) ? k_col[IW-1:0] : col;
  assign issue     = (state == DRAIN) && !rd_pending && (!out_valid || counts.ready);

  // line buffer: pixel of the row above, per column
  rctc_ram #(.WIDTH(CMP_BITS), .DEPTH(SIDE)) u_line_buf (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (s1_px),
    .raddr (col),
    .rdata (lb_rdata)
  );

  // column counts: read at acceptance, written back in the following cycle
  rctc_ram #(.WIDTH(COUNT_W), .DEPTH(SIDE)) u_col_cnt (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (cc_wdata),
    .raddr (cc_raddr),
    .rdata (cc_rdata)
  );

  // row counts: written once per row from the running accumulator
  rctc_ram #(.WIDTH(COUNT_W), .DEPTH(SIDE)) u_row_cnt (
    .clk   (clk),
    .we    (accept && last_col),
    .waddr (row),
    .wdata (row_cnt_next),
    .raddr (k[IW-1:0]),
    .rdata (rc_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= RUN;
      row        <= '0;
      col        <= '0;
      s1_valid   <= 1'b0;
      k          <= '0;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      s1_valid   <= accept;
      rd_pending <= issue;

      // raster position
      if (accept) begin
        if (last_col) begin
          col <= '0;
          row <= last_row ? '0 : row + IW'(1);
        end else begin
          col <= col + IW'(1);
        end
      end

      case (state)
        RUN: begin
          if (accept && last_col && last_row) begin
            state <= FLUSH;
          end
        end
        FLUSH: begin
          // last column write-back lands this cycle
          state <= DRAIN;
          k     <= '0;
        end
        DRAIN: begin
          if (issue) begin
            k <= k + KW'(1);
            if (k == KW'(2 * SIDE - 1)) begin
              state <= RUN;
            end
          end
        end
        default: begin
          state <= RUN;
        end
      endcase

      // output register: load on read return, else drop when taken
      if (rd_pending) begin
        out_valid <= 1'b1;
      end else if (counts.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      left_px <= px;
      row_acc <= row_cnt_next;
    end
    s1_col       <= col;
    s1_first_row <= (row == '0);
    s1_px        <= px;
    if (issue) begin
      rd_row   <= k_in_rows;
      rd_index <= INDEX_W'(k);
      rd_last  <= (k == KW'(2 * SIDE - 1));
    end
    if (rd_pending) begin
      out_index <= rd_index;
      out_count <= rd_row ? rc_rdata : cc_rdata;
      out_last  <= rd_last;
    end
  end

  assign counts.valid            = out_valid;
  assign counts.feature_index    = out_index;
  assign counts.transition_count = out_count;
  assign counts.last             = out_last;

endmodule
